// ----- rtl/lcdseq_pkg.sv -----
// Package: request codes, LCD command bytes and the sequencer microcode ROM.
package lcdseq_pkg;

	localparam int unsigned REQ_W      = 2;
	localparam int unsigned COORD_W    = 8;
	localparam int unsigned COLOR_W    = 16;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned SIZE_W     = 9;
	localparam int unsigned ROT_W      = 2;
	localparam int unsigned PC_W       = 4;
	localparam int unsigned SRC_W      = 3;
	localparam int unsigned CFG_IDX_W  = 4;
	localparam int unsigned CFG_DATA_W = 9;
	localparam int unsigned IN_DATA_W  = 4 * COORD_W + COLOR_W;

	localparam logic [REQ_W-1:0] REQ_WINDOW = 2'd0;
	localparam logic [REQ_W-1:0] REQ_PIXEL  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_DRAW   = 2'd2;
	localparam logic [REQ_W-1:0] REQ_ORIENT = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIENT = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BGR    = 4'd3;

	localparam logic [SIZE_W-1:0] WIDTH_RST  = 9'd128;
	localparam logic [SIZE_W-1:0] HEIGHT_RST = 9'd160;

	localparam logic [BYTE_W-1:0] CMD_COLUMN_ADDR = 8'h2A;
	localparam logic [BYTE_W-1:0] CMD_ROW_ADDR    = 8'h2B;
	localparam logic [BYTE_W-1:0] CMD_MEMORY_WR   = 8'h2C;
	localparam logic [BYTE_W-1:0] CMD_MADCTL      = 8'h36;
	localparam logic [BYTE_W-1:0] MADCTL_BGR      = 8'h08;

	localparam logic DC_CMD  = 1'b0;
	localparam logic DC_DATA = 1'b1;

	// byte sources of the datapath
	localparam logic [SRC_W-1:0] SRC_CONST = 3'd0;
	localparam logic [SRC_W-1:0] SRC_XS    = 3'd1;
	localparam logic [SRC_W-1:0] SRC_YS    = 3'd2;
	localparam logic [SRC_W-1:0] SRC_XE    = 3'd3;
	localparam logic [SRC_W-1:0] SRC_YE    = 3'd4;
	localparam logic [SRC_W-1:0] SRC_CHI   = 3'd5;
	localparam logic [SRC_W-1:0] SRC_CLO   = 3'd6;
	localparam logic [SRC_W-1:0] SRC_MAD   = 3'd7;

	// program entry points
	localparam logic [PC_W-1:0] PC_WINDOW = 4'd0;
	localparam logic [PC_W-1:0] PC_PIXEL  = 4'd11;
	localparam logic [PC_W-1:0] PC_ORIENT = 4'd13;

	typedef struct packed {
		logic              dc;
		logic [SRC_W-1:0]  src;
		logic [BYTE_W-1:0] opcode;
		logic              fin_win;  // end of program for a window request
		logic              fin;      // end of program
	} ucode_t;

	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		w = '{dc: DC_DATA, src: SRC_CONST, opcode: '0, fin_win: 1'b0, fin: 1'b0};
		case (pc)
			4'd0: begin
				w.dc = DC_CMD; w.opcode = CMD_COLUMN_ADDR;
			end
			4'd1: w.src = SRC_CONST;
			4'd2: w.src = SRC_XS;
			4'd3: w.src = SRC_CONST;
			4'd4: w.src = SRC_XE;
			4'd5: begin
				w.dc = DC_CMD; w.opcode = CMD_ROW_ADDR;
			end
			4'd6: w.src = SRC_CONST;
			4'd7: w.src = SRC_YS;
			4'd8: w.src = SRC_CONST;
			4'd9: w.src = SRC_YE;
			4'd10: begin
				w.dc = DC_CMD; w.opcode = CMD_MEMORY_WR; w.fin_win = 1'b1;
			end
			4'd11: w.src = SRC_CHI;
			4'd12: begin
				w.src = SRC_CLO; w.fin = 1'b1;
			end
			4'd13: begin
				w.dc = DC_CMD; w.opcode = CMD_MADCTL;
			end
			4'd14: begin
				w.src = SRC_MAD; w.fin = 1'b1;
			end
			default: w.fin = 1'b1;
		endcase
		return w;
	endfunction

	function automatic logic [BYTE_W-1:0] madctl_byte(input logic [ROT_W-1:0] rot,
			input logic bgr);
		logic [BYTE_W-1:0] m;
		case (rot)
			2'd0: m = 8'hC0;
			2'd1: m = 8'h60;
			2'd2: m = 8'h00;
			default: m = 8'hA0;
		endcase
		return bgr ? (m | MADCTL_BGR) : m;
	endfunction

endpackage

// ----- rtl/nine_bit_lcd_command_sequencer.sv -----
// Top level: 9-bit LCD command sequencer driven by a microcode ROM.
//
// Each request runs a short program in a ROM, one 9-bit word (tuser = D/C flag, tdata = byte)
// per cycle while the output is not stalled; the step counter walks the ROM and one item is in
// work at a time. Words per request: stream pixel 2, orientation 2, set window 11, draw 13 (a
// clipped draw sends nothing). The first word is loaded into the output register at the edge
// that takes the request, and the next request is taken only once the last word is loaded and
// the output is free, so no new pixel is taken before the last byte of the pixel before it.
// Configuration writes take effect at once and are always accepted.
module nine_bit_lcd_command_sequencer (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// x_start[7:0], y_start[15:8], x_end[23:16], y_end[31:24], color[47:32]
	input  logic [lcdseq_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// req_type[1:0]
	input  logic [lcdseq_pkg::REQ_W-1:0]           s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// word_byte[7:0]
	output logic [lcdseq_pkg::BYTE_W-1:0]          m_axis_tdata,
	// dc_flag[0]
	output logic                                   m_axis_tuser,
	output logic                                   m_axis_tlast,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [lcdseq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lcdseq_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import lcdseq_pkg::*;

	logic [SIZE_W-1:0]  width_q, height_q;
	logic [ROT_W-1:0]   orient_q;
	logic               bgr_q;

	logic               busy_q;
	logic [PC_W-1:0]    pc_q;
	logic [REQ_W-1:0]   req_q;
	logic [COORD_W-1:0] xs_q, ys_q, xe_q, ye_q;
	logic [COLOR_W-1:0] color_q;

	logic               out_valid_q;
	logic [BYTE_W-1:0]  out_byte_q;
	logic               out_dc_q, out_last_q;

	logic [COORD_W-1:0] in_xs, in_ys, in_xe, in_ye;
	logic [COLOR_W-1:0] in_color;
	logic [REQ_W-1:0]   cur_req;
	logic [COORD_W-1:0] cur_xs, cur_ys, cur_xe, cur_ye;
	logic [COLOR_W-1:0] cur_color;
	logic [SIZE_W-1:0]  clip_w, clip_h;
	logic               clipped, out_free, accept, emit, word_last;
	logic [PC_W-1:0]    entry_pc, step_pc;
	logic [BYTE_W-1:0]  word_byte;
	ucode_t             uw;

	assign in_xs    = s_axis_tdata[COORD_W-1:0];
	assign in_ys    = s_axis_tdata[2*COORD_W-1:COORD_W];
	assign in_xe    = (s_axis_tuser == REQ_DRAW) ? in_xs : s_axis_tdata[3*COORD_W-1:2*COORD_W];
	assign in_ye    = (s_axis_tuser == REQ_DRAW) ? in_ys : s_axis_tdata[4*COORD_W-1:3*COORD_W];
	assign in_color = s_axis_tdata[IN_DATA_W-1:4*COORD_W];

	assign cur_req   = busy_q ? req_q   : s_axis_tuser;
	assign cur_xs    = busy_q ? xs_q    : in_xs;
	assign cur_ys    = busy_q ? ys_q    : in_ys;
	assign cur_xe    = busy_q ? xe_q    : in_xe;
	assign cur_ye    = busy_q ? ye_q    : in_ye;
	assign cur_color = busy_q ? color_q : in_color;

	assign clip_w  = orient_q[0] ? height_q : width_q;
	assign clip_h  = orient_q[0] ? width_q  : height_q;
	assign clipped = ({1'b0, in_xs} >= clip_w) || ({1'b0, in_ys} >= clip_h);

	always_comb begin
		case (s_axis_tuser)
			REQ_PIXEL:  entry_pc = PC_PIXEL;
			REQ_ORIENT: entry_pc = PC_ORIENT;
			default:    entry_pc = PC_WINDOW;
		endcase
	end

	assign step_pc   = busy_q ? pc_q : entry_pc;
	assign uw        = ucode_rom(step_pc);
	assign word_last = uw.fin || (uw.fin_win && cur_req == REQ_WINDOW);

	always_comb begin
		case (uw.src)
			SRC_XS:  word_byte = cur_xs;
			SRC_YS:  word_byte = cur_ys;
			SRC_XE:  word_byte = cur_xe;
			SRC_YE:  word_byte = cur_ye;
			SRC_CHI: word_byte = cur_color[COLOR_W-1:BYTE_W];
			SRC_CLO: word_byte = cur_color[BYTE_W-1:0];
			SRC_MAD: word_byte = madctl_byte(orient_q, bgr_q);
			default: word_byte = uw.opcode;
		endcase
	end

	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !busy_q && out_free;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign emit          = (busy_q && out_free) ||
		(accept && !(s_axis_tuser == REQ_DRAW && clipped));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				busy_q      <= !word_last;
				pc_q        <= step_pc + 1'b1;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= s_axis_tuser;
			xs_q    <= in_xs;
			ys_q    <= in_ys;
			xe_q    <= in_xe;
			ye_q    <= in_ye;
			color_q <= in_color;
		end
		if (emit) begin
			out_byte_q <= word_byte;
			out_dc_q   <= uw.dc;
			out_last_q <= word_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			orient_q <= '0;
			bgr_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				CFG_ORIENT: orient_q <= cfg_data[ROT_W-1:0];
				CFG_BGR:    bgr_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tuser  = out_dc_q;
	assign m_axis_tlast  = out_last_q;

endmodule

// ----- rtl/lcdseq_checker.sv -----
// Checker: port-level assertions for the LCD command sequencer, with its bind.
module lcdseq_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   s_axis_tvalid,
	input logic                                   s_axis_tready,
	input logic [lcdseq_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	input logic [lcdseq_pkg::REQ_W-1:0]           s_axis_tuser,
	input logic                                   m_axis_tvalid,
	input logic                                   m_axis_tready,
	input logic [lcdseq_pkg::BYTE_W-1:0]          m_axis_tdata,
	input logic                                   m_axis_tuser,
	input logic                                   m_axis_tlast
);
	import lcdseq_pkg::*;

	// hold a stalled output beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
			$stable(m_axis_tlast))
		else $error("output beat changed while stalled");

	a_no_take_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("request taken while output stalled");

	a_pixel_first: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_PIXEL |=>
			m_axis_tvalid && m_axis_tuser == DC_DATA && !m_axis_tlast &&
			m_axis_tdata == $past(s_axis_tdata[IN_DATA_W-1:IN_DATA_W-BYTE_W]))
		else $error("pixel request did not start with its high byte");

	a_orient_first: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_ORIENT |=>
			m_axis_tvalid && m_axis_tuser == DC_CMD && m_axis_tdata == CMD_MADCTL &&
			!m_axis_tlast)
		else $error("orientation request did not start with madctl");

endmodule

bind nine_bit_lcd_command_sequencer lcdseq_checker u_lcdseq_checker (.*);

// ----- verif/nine_bit_lcd_command_sequencer_tb.sv -----
// Testbench for the 9-bit LCD command sequencer: directed and random stream traffic checked word by word.
`timescale 1ns / 1ps

module nine_bit_lcd_command_sequencer_tb;
	import lcdseq_pkg::*;

	localparam logic [BYTE_W-1:0] MADCTL_ROT0 = 8'hC0;
	localparam logic [BYTE_W-1:0] MADCTL_ROT1 = 8'h60;
	localparam logic [BYTE_W-1:0] MADCTL_ROT2 = 8'h00;
	localparam logic [BYTE_W-1:0] MADCTL_ROT3 = 8'hA0;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd9;
	localparam int SETTLE_CYCLES = 16;
	localparam int RX_HOLD_LEN   = 150;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic [COORD_W-1:0] y_end;
		logic [COORD_W-1:0] x_end;
		logic [COORD_W-1:0] y_start;
		logic [COORD_W-1:0] x_start;
	} lcd_payload_t;

	typedef struct packed {
		logic [REQ_W-1:0] kind;
		lcd_payload_t     payload;
	} lcd_req_t;

	typedef struct packed {
		logic              dc;
		logic [BYTE_W-1:0] data;
		logic              last;
	} lcd_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [REQ_W-1:0]      s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [BYTE_W-1:0]     m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  m_axis_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	lcd_req_t  req_q[$];
	lcd_word_t words_q[$];
	lcd_req_t  tx_req;
	lcd_word_t want_word;
	logic      in_taken = 1'b0;
	int        tx_idle_pct = 0;
	int        rx_idle_pct = 0;
	int        rx_hold_cycles = 0;
	int        errors = 0;

	logic [SIZE_W-1:0] panel_w = WIDTH_RST;
	logic [SIZE_W-1:0] panel_h = HEIGHT_RST;
	logic [ROT_W-1:0]  rot_sel = '0;
	logic              bgr_on = 1'b0;

	nine_bit_lcd_command_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void add_word(input logic dc, input logic [BYTE_W-1:0] b);
		words_q.push_back('{dc: dc, data: b, last: 1'b0});
	endfunction

	function automatic void add_window(input logic [COORD_W-1:0] x0, input logic [COORD_W-1:0] y0,
			input logic [COORD_W-1:0] x1, input logic [COORD_W-1:0] y1);
		add_word(DC_CMD, CMD_COLUMN_ADDR);
		add_word(DC_DATA, '0);
		add_word(DC_DATA, x0);
		add_word(DC_DATA, '0);
		add_word(DC_DATA, x1);
		add_word(DC_CMD, CMD_ROW_ADDR);
		add_word(DC_DATA, '0);
		add_word(DC_DATA, y0);
		add_word(DC_DATA, '0);
		add_word(DC_DATA, y1);
		add_word(DC_CMD, CMD_MEMORY_WR);
	endfunction

	function automatic void add_pixel(input logic [COLOR_W-1:0] color);
		add_word(DC_DATA, color[15:8]);
		add_word(DC_DATA, color[7:0]);
	endfunction

	function automatic void predict_words(input logic [REQ_W-1:0] kind, input lcd_payload_t p);
		int                n0;
		logic [SIZE_W-1:0] clip_w;
		logic [SIZE_W-1:0] clip_h;
		logic [BYTE_W-1:0] mad;
		n0 = words_q.size();
		case (kind)
			REQ_WINDOW: add_window(p.x_start, p.y_start, p.x_end, p.y_end);
			REQ_PIXEL: add_pixel(p.color);
			REQ_DRAW: begin
				clip_w = rot_sel[0] ? panel_h : panel_w;
				clip_h = rot_sel[0] ? panel_w : panel_h;
				if ({1'b0, p.x_start} < clip_w && {1'b0, p.y_start} < clip_h) begin
					add_window(p.x_start, p.y_start, p.x_start, p.y_start);
					add_pixel(p.color);
				end
			end
			default: begin
				case (rot_sel)
					2'd0: mad = MADCTL_ROT0;
					2'd1: mad = MADCTL_ROT1;
					2'd2: mad = MADCTL_ROT2;
					default: mad = MADCTL_ROT3;
				endcase
				if (bgr_on)
					mad = mad | MADCTL_BGR;
				add_word(DC_CMD, CMD_MADCTL);
				add_word(DC_DATA, mad);
			end
		endcase
		if (words_q.size() > n0)
			words_q[words_q.size() - 1].last = 1'b1;
	endfunction

	// sender
	always @(negedge clk) begin
		if (s_axis_tvalid && !in_taken) begin
		end else if (req_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
			tx_req = req_q.pop_front();
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= tx_req.payload;
			s_axis_tuser <= tx_req.kind;
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	// receiver
	always @(negedge clk) begin
		if (rx_hold_cycles > 0) begin
			rx_hold_cycles = rx_hold_cycles - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		in_taken <= s_axis_tvalid && s_axis_tready;
		if (s_axis_tvalid && s_axis_tready)
			predict_words(s_axis_tuser, lcd_payload_t'(s_axis_tdata));
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			if (words_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected word: expected none, actual dc=%0b byte=%02h last=%0b",
					$time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
			end else begin
				want_word = words_q.pop_front();
				if (m_axis_tuser !== want_word.dc) begin
					errors++;
					$display("%0t: dc_flag mismatch: expected %0b, actual %0b",
						$time, want_word.dc, m_axis_tuser);
				end
				if (m_axis_tdata !== want_word.data) begin
					errors++;
					$display("%0t: word_byte mismatch: expected %02h, actual %02h",
						$time, want_word.data, m_axis_tdata);
				end
				if (m_axis_tlast !== want_word.last) begin
					errors++;
					$display("%0t: last mismatch: expected %0b, actual %0b",
						$time, want_word.last, m_axis_tlast);
				end
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_WIDTH: panel_w = val;
			CFG_HEIGHT: panel_h = val;
			CFG_ORIENT: rot_sel = val[ROT_W-1:0];
			CFG_BGR: bgr_on = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_panel(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
			input logic [ROT_W-1:0] rot, input logic bgr);
		write_reg(CFG_WIDTH, w);
		write_reg(CFG_HEIGHT, h);
		write_reg(CFG_ORIENT, CFG_DATA_W'(rot));
		write_reg(CFG_BGR, CFG_DATA_W'(bgr));
	endtask

	task automatic queue_req(input logic [REQ_W-1:0] kind, input logic [COORD_W-1:0] xs,
			input logic [COORD_W-1:0] ys, input logic [COORD_W-1:0] xe,
			input logic [COORD_W-1:0] ye, input logic [COLOR_W-1:0] color);
		req_q.push_back('{kind: kind, payload: '{color: color, y_end: ye, x_end: xe,
			y_start: ys, x_start: xs}});
	endtask

	task automatic queue_random(input int n);
		int               pick;
		logic [REQ_W-1:0] kind;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 35)
				kind = REQ_PIXEL;
			else if (pick < 65)
				kind = REQ_DRAW;
			else if (pick < 85)
				kind = REQ_WINDOW;
			else
				kind = REQ_ORIENT;
			queue_req(kind, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
				COORD_W'($urandom), COLOR_W'($urandom));
		end
	endtask

	task automatic drain();
		while (req_q.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (words_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [SIZE_W-1:0] pick_size();
		case ($urandom_range(0, 7))
			0: return 9'd0;
			1: return 9'd1;
			2: return 9'd256;
			3: return 9'd511;
			default: return SIZE_W'($urandom_range(1, 256));
		endcase
	endfunction

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		tx_idle_pct = 31;
		rx_idle_pct = 48;

		queue_req(REQ_WINDOW, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000);
		queue_req(REQ_WINDOW, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
		queue_req(REQ_WINDOW, 8'h55, 8'hAA, 8'hA5, 8'h5A, 16'h1234);
		queue_req(REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'h0000);
		queue_req(REQ_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 16'hFFFF);
		queue_req(REQ_PIXEL, 8'h12, 8'h34, 8'h56, 8'h78, 16'hA55A);
		queue_req(REQ_DRAW, 8'h00, 8'h00, 8'hFF, 8'hFF, 16'h1234);
		queue_req(REQ_DRAW, 8'd127, 8'd159, 8'h00, 8'h00, 16'hFEDC);
		queue_req(REQ_DRAW, 8'd128, 8'd0, 8'h00, 8'h00, 16'h0F0F);
		queue_req(REQ_DRAW, 8'd0, 8'd160, 8'h00, 8'h00, 16'hF0F0);
		queue_req(REQ_DRAW, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
		queue_req(REQ_ORIENT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
		drain();

		write_reg(CFG_ORIENT, 9'd1);
		write_reg(CFG_BGR, 9'd1);
		queue_req(REQ_DRAW, 8'd159, 8'd127, 8'h00, 8'h00, 16'hBEEF);
		queue_req(REQ_DRAW, 8'd160, 8'd0, 8'h00, 8'h00, 16'h0001);
		queue_req(REQ_DRAW, 8'd0, 8'd128, 8'h00, 8'h00, 16'h8000);
		queue_req(REQ_ORIENT, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000);
		drain();

		set_panel(9'd1, 9'd256, 2'd2, 1'b1);
		queue_req(REQ_DRAW, 8'd0, 8'd255, 8'h00, 8'h00, 16'hC3C3);
		queue_req(REQ_DRAW, 8'd1, 8'd0, 8'h00, 8'h00, 16'h3C3C);
		queue_req(REQ_ORIENT, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000);
		drain();

		set_panel(9'd0, 9'd511, 2'd3, 1'b0);
		queue_req(REQ_DRAW, 8'd0, 8'd0, 8'h00, 8'h00, 16'h7E7E);
		queue_req(REQ_ORIENT, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000);
		drain();

		set_panel(9'd511, 9'd511, 2'd0, 1'b0);
		write_reg(CFG_UNUSED, 9'd0);
		queue_req(REQ_DRAW, 8'hFF, 8'hFF, 8'h00, 8'h00, 16'h5A5A);
		queue_req(REQ_ORIENT, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			tx_idle_pct = (ph < 2) ? 31 : (ph < 4) ? 48 : 0;
			rx_idle_pct = (ph < 2) ? 48 : (ph < 4) ? 31 : 0;
			set_panel(pick_size(), pick_size(), ROT_W'($urandom_range(0, 3)),
				1'($urandom_range(0, 1)));
			if (ph == 4)
				rx_hold_cycles = RX_HOLD_LEN;
			queue_random(18);
			drain();
		end

		if (errors == 0 && words_q.size() == 0) begin
			$display("nine_bit_lcd_command_sequencer test passed");
		end else begin
			$display("nine_bit_lcd_command_sequencer test failed");
		end
		$finish;
	end

	initial begin
		#1_000_000;
		$display("nine_bit_lcd_command_sequencer test failed");
		$finish;
	end

endmodule

// ----- nine_bit_lcd_command_sequencer.f -----
rtl/lcdseq_pkg.sv
rtl/nine_bit_lcd_command_sequencer.sv
rtl/lcdseq_checker.sv
verif/nine_bit_lcd_command_sequencer_tb.sv
